// ----- hdl/dock_layout_placer_defines.svh -----
// assertion macros shared by the dock layout placer modules
`ifndef DOCK_LAYOUT_PLACER_DEFINES_SVH
`define DOCK_LAYOUT_PLACER_DEFINES_SVH

// same-cycle implication, checked on clk, masked while rst_n is low
`define DLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, masked while rst_n is low
`define DLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dlp_pkg.sv -----
// types and constants of the dock layout placer
`timescale 1ns / 1ps

package dlp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECORATED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING   = 3'd5;

  // dock modes
  localparam logic [2:0] DOCK_NONE     = 3'd0;
  localparam logic [2:0] DOCK_TOP      = 3'd1;
  localparam logic [2:0] DOCK_BOTTOM   = 3'd2;
  localparam logic [2:0] DOCK_LEFT     = 3'd3;
  localparam logic [2:0] DOCK_RIGHT    = 3'd4;
  localparam logic [2:0] DOCK_FILL     = 3'd5;
  localparam logic [2:0] DOCK_CENTER   = 3'd6;
  localparam logic [2:0] DOCK_ALT_NONE = 3'd7;

  // frame offsets of a decorated parent
  localparam logic [31:0] DEC_DX = 32'd5;
  localparam logic [31:0] DEC_DY = 32'd35;
  localparam logic [31:0] DEC_DW = 32'd10;
  localparam logic [31:0] DEC_DH = 32'd40;

  typedef struct packed {
    logic               first;
    logic signed [15:0] child_x;
    logic signed [15:0] child_y;
    logic signed [15:0] child_w;
    logic signed [15:0] child_h;
    logic signed [15:0] margin_left;
    logic signed [15:0] margin_top;
    logic signed [15:0] margin_right;
    logic signed [15:0] margin_bottom;
    logic [2:0]         dock_sel;
    logic               hidden;
  } dlp_in_t;

  typedef struct packed {
    logic               placed;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_w;
    logic signed [31:0] screen_h;
  } dlp_out_t;

  // four running edges or the padded client area
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] right;
    logic [31:0] bottom;
  } dlp_edges_t;

  // parent origin and frame flag for absolutely placed children
  typedef struct packed {
    logic signed [15:0] parent_x;
    logic signed [15:0] parent_y;
    logic               decorated;
  } dlp_frame_t;

endpackage

// ----- hdl/dlp_cfg.sv -----
// configuration registers and the registered client area of the parent
`timescale 1ns / 1ps

module dlp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [dlp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [63:0]                   wr_data,
  output dlp_pkg::dlp_frame_t           frame,
  output dlp_pkg::dlp_edges_t           client
);
  import dlp_pkg::*;

  logic signed [15:0] parent_x_r;
  logic signed [15:0] parent_y_r;
  logic [14:0]        parent_w_r;
  logic [14:0]        parent_h_r;
  logic               decorated_r;
  logic [63:0]        padding_r;
  dlp_edges_t         client_r;
  dlp_edges_t         client_nxt;

  logic [31:0] px, py, pw, ph, pl, pt, pr, pb;
  logic [31:0] dx, dy, dw, dh;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parent_x_r  <= '0;
      parent_y_r  <= '0;
      parent_w_r  <= '0;
      parent_h_r  <= '0;
      decorated_r <= 1'b0;
      padding_r   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PARENT_X:  parent_x_r  <= wr_data[15:0];
        CFG_PARENT_Y:  parent_y_r  <= wr_data[15:0];
        CFG_PARENT_W:  parent_w_r  <= wr_data[14:0];
        CFG_PARENT_H:  parent_h_r  <= wr_data[14:0];
        CFG_DECORATED: decorated_r <= wr_data[0];
        CFG_PADDING:   padding_r   <= wr_data;
        default: ;
      endcase
    end
  end

  // operands widened to 32 bits
  assign px = {{16{parent_x_r[15]}}, parent_x_r};
  assign py = {{16{parent_y_r[15]}}, parent_y_r};
  assign pw = {17'd0, parent_w_r};
  assign ph = {17'd0, parent_h_r};
  assign pl = {16'd0, padding_r[15:0]};
  assign pt = {16'd0, padding_r[31:16]};
  assign pr = {16'd0, padding_r[47:32]};
  assign pb = {16'd0, padding_r[63:48]};
  assign dx = decorated_r ? DEC_DX : '0;
  assign dy = decorated_r ? DEC_DY : '0;
  assign dw = decorated_r ? DEC_DW : '0;
  assign dh = decorated_r ? DEC_DH : '0;

  // client area edges, each edge moved inward by the padding on its own side
  always_comb begin
    client_nxt.left   = px + dx + pl;
    client_nxt.top    = py + dy + pt;
    client_nxt.right  = px + pw + dx - dw - pr;
    client_nxt.bottom = py + ph + dy - dh - pb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_r <= '0;
    end else begin
      client_r <= client_nxt;
    end
  end

  assign client = client_r;

  assign frame.parent_x  = parent_x_r;
  assign frame.parent_y  = parent_y_r;
  assign frame.decorated = decorated_r;

endmodule

// ----- hdl/dlp_core.sv -----
// running dock edges and the placement of one child
`timescale 1ns / 1ps

module dlp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  dlp_pkg::dlp_in_t    item,
  input  dlp_pkg::dlp_frame_t frame,
  input  dlp_pkg::dlp_edges_t client,
  output dlp_pkg::dlp_out_t   result
);
  import dlp_pkg::*;

  dlp_edges_t  edges_r;
  dlp_edges_t  edges_nxt;
  dlp_edges_t  base;
  logic [31:0] cx, cy, cw, ch, ml, mt, mr, mb;
  logic [31:0] dx, dy;
  logic [31:0] span_w, span_h;
  logic [31:0] hsum, vsum;
  logic [31:0] off_w, off_h;
  logic [31:0] rnd_w, rnd_h;
  logic [31:0] half_w, half_h;
  logic [31:0] x, y, w, h;
  logic        clamp;

  // sign extension of the child fields
  assign cx = {{16{item.child_x[15]}}, item.child_x};
  assign cy = {{16{item.child_y[15]}}, item.child_y};
  assign cw = {{16{item.child_w[15]}}, item.child_w};
  assign ch = {{16{item.child_h[15]}}, item.child_h};
  assign ml = {{16{item.margin_left[15]}}, item.margin_left};
  assign mt = {{16{item.margin_top[15]}}, item.margin_top};
  assign mr = {{16{item.margin_right[15]}}, item.margin_right};
  assign mb = {{16{item.margin_bottom[15]}}, item.margin_bottom};
  assign dx = frame.decorated ? DEC_DX : '0;
  assign dy = frame.decorated ? DEC_DY : '0;

  // first child of a pass starts from the client area
  assign base   = item.first ? client : edges_r;
  assign span_w = base.right - base.left;
  assign span_h = base.bottom - base.top;
  assign hsum   = ml + mr;
  assign vsum   = mt + mb;

  // centre offset halved with truncation toward zero
  assign off_w  = span_w - cw;
  assign off_h  = span_h - ch;
  assign rnd_w  = off_w + {31'd0, off_w[31]};
  assign rnd_h  = off_h + {31'd0, off_h[31]};
  assign half_w = {rnd_w[31], rnd_w[31:1]};
  assign half_h = {rnd_h[31], rnd_h[31:1]};

  // placement by dock mode
  always_comb begin
    x         = base.left + ml;
    y         = base.top + mt;
    w         = cw;
    h         = ch;
    clamp     = 1'b1;
    edges_nxt = base;
    unique case (item.dock_sel)
      DOCK_TOP: begin
        w             = span_w - hsum;
        edges_nxt.top = base.top + ch + vsum;
      end
      DOCK_BOTTOM: begin
        y                = base.bottom - ch - mb;
        w                = span_w - hsum;
        edges_nxt.bottom = base.bottom - (ch + vsum);
      end
      DOCK_LEFT: begin
        h              = span_h - vsum;
        edges_nxt.left = base.left + cw + hsum;
      end
      DOCK_RIGHT: begin
        x               = base.right - cw - mr;
        h               = span_h - vsum;
        edges_nxt.right = base.right - (cw + hsum);
      end
      DOCK_FILL: begin
        w = span_w - hsum;
        h = span_h - vsum;
      end
      DOCK_CENTER: begin
        x = base.left + half_w;
        y = base.top + half_h;
      end
      default: begin
        // dock none and its alias: absolute in the parent, size as given
        x     = {{16{frame.parent_x[15]}}, frame.parent_x} + cx + dx;
        y     = {{16{frame.parent_y[15]}}, frame.parent_y} + cy + dy;
        clamp = 1'b0;
      end
    endcase

    if (item.hidden) begin
      edges_nxt       = base;
      result          = '0;
    end else begin
      result.placed   = 1'b1;
      result.screen_x = x;
      result.screen_y = y;
      result.screen_w = (clamp && w[31]) ? '0 : w;
      result.screen_h = (clamp && h[31]) ? '0 : h;
    end
  end

  // edge state moves with each child that leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edges_r <= '0;
    end else if (adv) begin
      edges_r <= edges_nxt;
    end
  end

endmodule

// ----- hdl/dock_layout_placer.sv -----
// top level of the dock layout placer: channel registers around the placement core
//
//  channel | ports                               | direction | transaction
//  in      | in_valid, in_stall, in_data         | to block  | one child
//  out     | out_valid, out_stall, out_data      | from block| one placed child
//  cfg     | cfg_valid, cfg_ready, cfg_index/data| to block  | one register write
//
// one child per cycle unless a result waits under out_stall; a result passes the
// input register and the result register; the path from the input register
// through the dock edges to the result register sets the cycle, and the running
// edges are updated in the same cycle as the result register is loaded
// rst_n is synchronous: edges, valid flags and config registers clear; the client
// area is registered from the config registers; cfg_ready is always high
// while a result waits under out_stall, one more child is held in the input register
`timescale 1ns / 1ps
`include "dock_layout_placer_defines.svh"

module dock_layout_placer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dlp_pkg::dlp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dlp_pkg::dlp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import dlp_pkg::*;

  logic       in_valid_r;
  dlp_in_t    in_data_r;
  logic       out_valid_r;
  dlp_out_t   out_data_r;
  logic       out_load;
  logic       adv;
  logic       in_take;
  dlp_frame_t frame;
  dlp_edges_t client;
  dlp_out_t   result;

  // handshake control
  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || !out_stall;
  assign adv       = in_valid_r && out_load;
  assign in_stall  = in_valid_r && !out_load;
  assign in_take   = in_valid && !in_stall;

  dlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .frame    (frame),
    .client   (client)
  );

  dlp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_data_r),
    .frame  (frame),
    .client (client),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `DLP_ASSERT_NXT(a_adv_fills_out, adv, out_valid_r, "child left input stage without a result")
  `DLP_ASSERT_NXT(a_hold_in, in_valid_r && out_valid_r && out_stall, in_valid_r && $stable(in_data_r), "held child lost under stall")
  `DLP_ASSERT_NXT(a_hidden_unplaced, adv && in_data_r.hidden, !out_data_r.placed, "hidden child reported as placed")
  `DLP_ASSERT_NXT(a_docked_w_clamped, adv && !in_data_r.hidden && in_data_r.dock_sel != DOCK_NONE && in_data_r.dock_sel != DOCK_ALT_NONE, !out_data_r.screen_w[31] && !out_data_r.screen_h[31], "docked size below zero")

endmodule
